// ===== design/asc_pkg.sv =====
// Shared types, codes and character mapping functions for the serial channel.
package asc_pkg;

  // Item kinds carried on the input channel
  typedef enum logic [2:0] {
    MODE_LINE_IN  = 3'd0,
    MODE_RD_STAT  = 3'd1,
    MODE_RD_DATA  = 3'd2,
    MODE_WR_CTRL  = 3'd3,
    MODE_WR_DATA  = 3'd4,
    MODE_TX_TICK  = 3'd5
  } asc_mode_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TIMED_MODE   = 2'd0,
    CFG_UPCASE_INPUT = 2'd1,
    CFG_BACKSPACE    = 2'd2,
    CFG_SEVEN_BIT    = 2'd3
  } asc_cfg_idx_t;

  // Backspace mapping modes
  localparam logic [1:0] BS_NONE       = 2'd0;
  localparam logic [1:0] BS_UNDERSCORE = 2'd1;
  localparam logic [1:0] BS_RUBOUT     = 2'd2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 2;

  // Control word fields
  localparam logic [7:0] CTRL_RX_IE     = 8'h80;
  localparam logic [7:0] CTRL_TX_MASK   = 8'h60;
  localparam logic [7:0] CTRL_TX_IE     = 8'h20;
  localparam logic [7:0] CTRL_MRST_MASK = 8'h03;

  // Characters
  localparam logic [7:0] CH_BACKSPACE  = 8'h08;
  localparam logic [7:0] CH_RUBOUT     = 8'h7F;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_LO   = 8'd96;
  localparam logic [7:0] CH_LOWER_HI   = 8'd123;
  localparam logic [7:0] CH_CASE_DIFF  = 8'h20;
  localparam logic [7:0] CH_7BIT_MASK  = 8'h7F;

  typedef struct packed {
    logic       timed_mode;
    logic       upcase_input;
    logic [1:0] backspace_mode;
    logic       seven_bit_output;
  } asc_cfg_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_in;
    logic       tx_ready;
  } asc_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } asc_result_t;

  typedef struct packed {
    logic       rx_int_enable;
    logic       tx_int_enable;
    logic       rx_full;
    logic       tx_empty;
    logic       overrun_flag;
    logic       overrun_pending;
    logic [7:0] held_byte;
  } asc_state_t;

  localparam asc_state_t STATE_RESET = '{
    rx_int_enable:   1'b0,
    tx_int_enable:   1'b0,
    rx_full:         1'b0,
    tx_empty:        1'b1,
    overrun_flag:    1'b0,
    overrun_pending: 1'b0,
    held_byte:       8'h00
  };

  // Received byte as seen by a data read
  function automatic logic [7:0] asc_map_in(input logic [7:0] d, input logic upcase,
                                            input logic [1:0] bs_mode);
    logic [7:0] r;
    r = d;
    if (upcase && (r > CH_LOWER_LO) && (r < CH_LOWER_HI)) begin
      r = r - CH_CASE_DIFF;
    end
    if (bs_mode == BS_UNDERSCORE) begin
      if ((r == CH_BACKSPACE) || (r == CH_RUBOUT)) begin
        r = CH_UNDERSCORE;
      end
    end else if (bs_mode == BS_RUBOUT) begin
      if (r == CH_BACKSPACE) begin
        r = CH_RUBOUT;
      end
    end
    return r;
  endfunction

  // Byte as sent to the line by a data write
  function automatic logic [7:0] asc_map_out(input logic [7:0] d, input logic seven_bit,
                                             input logic [1:0] bs_mode);
    logic [7:0] r;
    r = d;
    if (seven_bit) begin
      r = r & CH_7BIT_MASK;
    end
    if ((bs_mode == BS_UNDERSCORE) && (r == CH_UNDERSCORE)) begin
      r = CH_RUBOUT;
    end
    return r;
  endfunction

endpackage

// ===== design/asc_if.sv =====
// Valid/ready channel interfaces for input items and results.
interface asc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] data_in;
  logic       tx_ready;

  modport source (output valid, output mode, output data_in, output tx_ready, input ready);
  modport sink (input valid, input mode, input data_in, input tx_ready, output ready);
  modport monitor (input valid, input ready, input mode, input data_in, input tx_ready);
endinterface

interface asc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq;
  logic       tx_valid;
  logic [7:0] tx_byte;

  modport source (output valid, output read_data, output irq, output tx_valid,
                  output tx_byte, input ready);
  modport sink (input valid, input read_data, input irq, input tx_valid,
                input tx_byte, output ready);
  modport monitor (input valid, input ready, input read_data, input irq,
                   input tx_valid, input tx_byte);
endinterface

// ===== design/acia_serial_channel_unit.sv =====
// Each item is captured in the input register and its result in the result register before it is offered.
// Throughput: one item per cycle; the input stalls only while both the input register and
// the result register are occupied and the waiting result is not being taken.
// Reset: synchronous, active low; clears the channel flags (transmit-empty set),
// the held byte, the configuration registers and both pipeline valids.
// Top level: one 6850-style serial channel with character mapping.
module acia_serial_channel_unit
  import asc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  asc_in_if.sink              in_chan,
  asc_out_if.source           out_chan,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  asc_cfg_t    cfg;
  asc_item_t   s1_item_r;
  logic        s1_valid_r;
  asc_result_t res_r;
  logic        out_valid_r;
  asc_result_t core_res;
  logic        adv;
  logic        in_fire;

  // result stage free or being drained this cycle
  assign adv     = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv || !s1_valid_r;
  assign in_fire = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= '{mode: in_chan.mode, data_in: in_chan.data_in,
                     tx_ready: in_chan.tx_ready};
    end
  end

  asc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  asc_channel_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_en (s1_valid_r && adv),
    .item    (s1_item_r),
    .cfg     (cfg),
    .result  (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      res_r <= core_res;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.read_data = res_r.read_data;
  assign out_chan.irq       = res_r.irq;
  assign out_chan.tx_valid  = res_r.tx_valid;
  assign out_chan.tx_byte   = res_r.tx_byte;

endmodule

// ===== design/asc_cfg_regs.sv =====
// Configuration registers with a plain write port.
module asc_cfg_regs
  import asc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output asc_cfg_t            cfg
);

  asc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (asc_cfg_idx_t'(cfg_index))
        CFG_TIMED_MODE:   cfg_r.timed_mode       <= cfg_wdata[0];
        CFG_UPCASE_INPUT: cfg_r.upcase_input     <= cfg_wdata[0];
        CFG_BACKSPACE:    cfg_r.backspace_mode   <= cfg_wdata;
        CFG_SEVEN_BIT:    cfg_r.seven_bit_output <= cfg_wdata[0];
        default:          cfg_r                  <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/asc_channel_core.sv =====
// Channel state and the per-item update and result logic.
module asc_channel_core
  import asc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_en,
  input  asc_item_t   item,
  input  asc_cfg_t    cfg,
  output asc_result_t result
);

  asc_state_t st_r, st_nxt;
  logic       paced;
  logic       te_bit;

  assign paced  = st_r.tx_int_enable | cfg.timed_mode;
  assign te_bit = paced ? st_r.tx_empty : item.tx_ready;

  always_comb begin
    st_nxt = st_r;
    result = '0;
    unique case (item.mode)
      MODE_LINE_IN: begin
        if (st_r.rx_full) begin
          st_nxt.overrun_pending = 1'b1;
        end else begin
          st_nxt.held_byte = item.data_in;
          st_nxt.rx_full   = 1'b1;
        end
      end
      MODE_RD_STAT: begin
        result.read_data = {(st_r.rx_int_enable & st_r.rx_full) |
                              (st_r.tx_int_enable & st_r.tx_empty),
                            1'b0, st_r.overrun_flag, 3'b000, te_bit, st_r.rx_full};
      end
      MODE_RD_DATA: begin
        if (st_r.rx_full) begin
          // pending overrun surfaces only once the good byte is read
          st_nxt.rx_full         = 1'b0;
          st_nxt.overrun_flag    = st_r.overrun_pending;
          st_nxt.overrun_pending = 1'b0;
          result.read_data = asc_map_in(st_r.held_byte, cfg.upcase_input,
                                        cfg.backspace_mode);
        end
      end
      MODE_WR_CTRL: begin
        if ((item.data_in & CTRL_MRST_MASK) == CTRL_MRST_MASK) begin
          st_nxt.rx_int_enable   = 1'b0;
          st_nxt.tx_int_enable   = 1'b0;
          st_nxt.rx_full         = 1'b0;
          st_nxt.tx_empty        = 1'b1;
          st_nxt.overrun_flag    = 1'b0;
          st_nxt.overrun_pending = 1'b0;
        end else begin
          st_nxt.rx_int_enable = |(item.data_in & CTRL_RX_IE);
          st_nxt.tx_int_enable = (item.data_in & CTRL_TX_MASK) == CTRL_TX_IE;
        end
      end
      MODE_WR_DATA: begin
        result.tx_valid = 1'b1;
        result.tx_byte  = asc_map_out(item.data_in, cfg.seven_bit_output,
                                      cfg.backspace_mode);
        if (paced) begin
          st_nxt.tx_empty = 1'b0;
        end
      end
      MODE_TX_TICK: begin
        if (paced) begin
          st_nxt.tx_empty = 1'b1;
        end
      end
      default: begin
      end
    endcase
    result.irq = (st_nxt.rx_int_enable & st_nxt.rx_full) |
                 (st_nxt.tx_int_enable & st_nxt.tx_empty);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else if (item_en) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== design/asc_checker.sv =====
// Port-level checks for the serial channel, bound to the top level.
module asc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic       out_irq,
  input logic       out_tx_valid,
  input logic [7:0] out_tx_byte
);

  // a transmit result never carries read data
  a_tx_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_tx_valid) |-> (out_read_data == 8'h00))
    else $error("read_data non-zero on a transmit result");

  // no byte shown without a transmit
  a_tx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_tx_valid) |-> (out_tx_byte == 8'h00))
    else $error("tx_byte non-zero without tx_valid");

  // nothing presented straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_read_data) && $stable(out_irq) &&
       $stable(out_tx_valid) && $stable(out_tx_byte)))
    else $error("stalled result changed");

endmodule

bind acia_serial_channel_unit asc_checker u_asc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_read_data (out_chan.read_data),
  .out_irq       (out_chan.irq),
  .out_tx_valid  (out_chan.tx_valid),
  .out_tx_byte   (out_chan.tx_byte)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the serial channel unit: predicting scoreboard, directed and random traffic.
module tb;
  import asc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CycleLimit  = 300000;
  localparam int          PhaseCount  = 10;
  localparam int          PhaseItems  = 120;
  localparam int          MaxGap      = 13;

  localparam logic [7:0]  STAT_RX_FULL  = 8'h01;
  localparam logic [7:0]  STAT_TX_EMPTY = 8'h02;
  localparam logic [7:0]  STAT_OVERRUN  = 8'h20;
  localparam logic [7:0]  STAT_IRQ      = 8'h80;

  // Mode codes with no function in the channel
  localparam logic [2:0]  MODE_SPARE_A  = 3'd6;
  localparam logic [2:0]  MODE_SPARE_B  = 3'd7;
  // Backspace code with no function; behaves as none
  localparam logic [1:0]  BS_SPARE      = 2'd3;

  localparam logic [7:0]  CH_LOWER_A    = 8'h61;
  localparam logic [7:0]  CH_LOWER_Z    = 8'h7A;

  class channel_scoreboard;
    asc_cfg_t    cfg;
    asc_state_t  st;
    asc_result_t pending_results[$];
    int          errors;

    function new();
      cfg    = '0;
      st     = STATE_RESET;
      errors = 0;
    endfunction

    function void set_config(asc_cfg_t c);
      cfg = c;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function logic line_irq();
      return (st.rx_int_enable & st.rx_full) | (st.tx_int_enable & st.tx_empty);
    endfunction

    function logic [7:0] rx_view(logic [7:0] b);
      logic [7:0] c;
      c = b;
      if (cfg.upcase_input && c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
        c = c - CH_CASE_DIFF;
      end
      if (cfg.backspace_mode == BS_UNDERSCORE) begin
        if (c == CH_BACKSPACE || c == CH_RUBOUT) c = CH_UNDERSCORE;
      end else if (cfg.backspace_mode == BS_RUBOUT) begin
        if (c == CH_BACKSPACE) c = CH_RUBOUT;
      end
      return c;
    endfunction

    function logic [7:0] tx_view(logic [7:0] b);
      logic [7:0] c;
      c = b;
      if (cfg.seven_bit_output) c = c & CH_7BIT_MASK;
      if (cfg.backspace_mode == BS_UNDERSCORE && c == CH_UNDERSCORE) c = CH_RUBOUT;
      return c;
    endfunction

    // Advance the channel state by one accepted item and queue its result
    function void note_item(asc_item_t it);
      asc_result_t r;
      logic        paced;
      logic        te;
      r     = '0;
      paced = st.tx_int_enable | cfg.timed_mode;
      case (it.mode)
        MODE_LINE_IN: begin
          if (st.rx_full) begin
            st.overrun_pending = 1'b1;
          end else begin
            st.held_byte = it.data_in;
            st.rx_full   = 1'b1;
          end
        end
        MODE_RD_STAT: begin
          te = paced ? st.tx_empty : it.tx_ready;
          if (st.rx_full)      r.read_data |= STAT_RX_FULL;
          if (te)              r.read_data |= STAT_TX_EMPTY;
          if (st.overrun_flag) r.read_data |= STAT_OVERRUN;
          if (line_irq())      r.read_data |= STAT_IRQ;
        end
        MODE_RD_DATA: begin
          if (st.rx_full) begin
            st.rx_full         = 1'b0;
            st.overrun_flag    = st.overrun_pending;
            st.overrun_pending = 1'b0;
            r.read_data        = rx_view(st.held_byte);
          end
        end
        MODE_WR_CTRL: begin
          st.rx_int_enable = (it.data_in & CTRL_RX_IE) != 0;
          st.tx_int_enable = (it.data_in & CTRL_TX_MASK) == CTRL_TX_IE;
          if ((it.data_in & CTRL_MRST_MASK) == CTRL_MRST_MASK) begin
            st.rx_int_enable   = 1'b0;
            st.tx_int_enable   = 1'b0;
            st.rx_full         = 1'b0;
            st.tx_empty        = 1'b1;
            st.overrun_flag    = 1'b0;
            st.overrun_pending = 1'b0;
          end
        end
        MODE_WR_DATA: begin
          r.tx_valid = 1'b1;
          r.tx_byte  = tx_view(it.data_in);
          if (paced) st.tx_empty = 1'b0;
        end
        MODE_TX_TICK: begin
          if (paced) st.tx_empty = 1'b1;
        end
        default: ;
      endcase
      r.irq = line_irq();
      pending_results.push_back(r);
    endfunction

    function void check_result(asc_result_t got);
      asc_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result expected none actual %h/%b/%b/%h", $time,
                 got.read_data, got.irq, got.tx_valid, got.tx_byte);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.read_data !== want.read_data) begin
        $display("%0t: read_data expected %h actual %h", $time, want.read_data, got.read_data);
        errors++;
      end
      if (got.irq !== want.irq) begin
        $display("%0t: irq expected %b actual %b", $time, want.irq, got.irq);
        errors++;
      end
      if (got.tx_valid !== want.tx_valid) begin
        $display("%0t: tx_valid expected %b actual %b", $time, want.tx_valid, got.tx_valid);
        errors++;
      end
      if (got.tx_byte !== want.tx_byte) begin
        $display("%0t: tx_byte expected %h actual %h", $time, want.tx_byte, got.tx_byte);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  asc_in_if  in_if();
  asc_out_if out_if();

  channel_scoreboard sb;

  int cycles;
  bit in_fired;
  bit out_fired;
  bit in_burst;
  bit out_burst;
  int out_stall;

  acia_serial_channel_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Transfers on both channels are seen at the rising edge
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_item('{mode: in_if.mode, data_in: in_if.data_in, tx_ready: in_if.tx_ready});
        in_fired = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_result('{read_data: out_if.read_data, irq: out_if.irq,
                          tx_valid: out_if.tx_valid, tx_byte: out_if.tx_byte});
        out_fired = 1'b1;
      end
    end
  end

  // Receiver back-pressure: a fresh stall is drawn after every result transfer
  always @(negedge clk) begin
    if (out_fired) begin
      out_fired = 1'b0;
      if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
      out_stall = out_burst ? 0 : $urandom_range(0, MaxGap);
    end
    if (out_stall > 0) begin
      out_if.ready <= 1'b0;
      out_stall--;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  function automatic asc_item_t make_item(logic [2:0] m, logic [7:0] d);
    asc_item_t it;
    it.mode     = m;
    it.data_in  = d;
    it.tx_ready = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Bytes weighted toward the characters the mapping treats specially
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: b = CH_BACKSPACE;
      1: b = CH_RUBOUT;
      2: b = CH_UNDERSCORE;
      3: b = CH_UNDERSCORE | 8'h80;
      4: b = CH_BACKSPACE | 8'h80;
      5: b = CH_LOWER_A + 8'($urandom_range(0, 25));
      6: begin
        case ($urandom_range(0, 5))
          0: b = 8'h00;
          1: b = 8'hFF;
          2: b = CH_LOWER_LO;
          3: b = CH_LOWER_HI;
          4: b = CH_LOWER_A | 8'h80;
          default: b = CH_LOWER_Z;
        endcase
      end
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // Control words, master reset kept fairly rare
  function automatic logic [7:0] pick_ctrl();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if ((c & CTRL_MRST_MASK) == CTRL_MRST_MASK && $urandom_range(0, 3) != 0) begin
      c[1:0] = 2'($urandom_range(0, 2));
    end
    return c;
  endfunction

  function automatic asc_item_t pick_item();
    logic [2:0] m;
    logic [7:0] d;
    d = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 19))
      0, 1, 2, 3:   begin m = MODE_LINE_IN; d = pick_byte(); end
      4, 5, 6, 7:   m = MODE_RD_STAT;
      8, 9, 10, 11: m = MODE_RD_DATA;
      12, 13:       begin m = MODE_WR_CTRL; d = pick_ctrl(); end
      14, 15, 16:   begin m = MODE_WR_DATA; d = pick_byte(); end
      17, 18:       m = MODE_TX_TICK;
      default:      m = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
    endcase
    return make_item(m, d);
  endfunction

  function automatic asc_cfg_t pick_config(int p);
    asc_cfg_t c;
    case (p)
      0: c = '0;
      1: c = '{timed_mode: 1'b1, upcase_input: 1'b1, backspace_mode: BS_RUBOUT,
               seven_bit_output: 1'b1};
      2: c = '{timed_mode: 1'b0, upcase_input: 1'b1, backspace_mode: BS_UNDERSCORE,
               seven_bit_output: 1'b1};
      3: c = '{timed_mode: 1'b1, upcase_input: 1'b0, backspace_mode: BS_UNDERSCORE,
               seven_bit_output: 1'b0};
      4: c = '{timed_mode: 1'b0, upcase_input: 1'b0, backspace_mode: BS_SPARE,
               seven_bit_output: 1'b1};
      default: begin
        c.timed_mode       = 1'($urandom_range(0, 1));
        c.upcase_input     = 1'($urandom_range(0, 1));
        c.backspace_mode   = 2'($urandom_range(0, 3));
        c.seven_bit_output = 1'($urandom_range(0, 1));
      end
    endcase
    return c;
  endfunction

  // Called at a falling edge with the input channel idle
  task automatic load_config(asc_cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TIMED_MODE;
    cfg_wdata <= CfgDataW'(c.timed_mode);
    @(negedge clk);
    cfg_index <= CFG_UPCASE_INPUT;
    cfg_wdata <= CfgDataW'(c.upcase_input);
    @(negedge clk);
    cfg_index <= CFG_BACKSPACE;
    cfg_wdata <= c.backspace_mode;
    @(negedge clk);
    cfg_index <= CFG_SEVEN_BIT;
    cfg_wdata <= CfgDataW'(c.seven_bit_output);
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_config(c);
  endtask

  task automatic send_item(asc_item_t it);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.mode     <= it.mode;
    in_if.data_in  <= it.data_in;
    in_if.tx_ready <= it.tx_ready;
    in_fired = 1'b0;
    do @(negedge clk); while (!in_fired);
    if ($urandom_range(0, 29) == 0) in_burst = !in_burst;
  endtask

  task automatic wait_drained(int settle);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic run_random(int n);
    int k;
    int hold_at;
    bit held;
    k       = 0;
    held    = 1'b0;
    hold_at = $urandom_range(0, n - 1);
    while (k < n) begin
      if (!held && k >= hold_at) begin
        wait_drained(1);
        held = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          // receive: byte arrives, poll, read it back
          send_item(make_item(MODE_LINE_IN, pick_byte()));
          send_item(make_item(MODE_RD_STAT, 8'($urandom_range(0, 255))));
          send_item(make_item(MODE_RD_DATA, 8'($urandom_range(0, 255))));
          k += 3;
        end
        2: begin
          // transmit: poll, send, line finishes
          send_item(make_item(MODE_RD_STAT, 8'($urandom_range(0, 255))));
          send_item(make_item(MODE_WR_DATA, pick_byte()));
          send_item(make_item(MODE_TX_TICK, 8'($urandom_range(0, 255))));
          k += 3;
        end
        default: begin
          send_item(pick_item());
          k++;
        end
      endcase
    end
  endtask

  initial begin
    sb             = new();
    cycles         = 0;
    in_fired       = 1'b0;
    out_fired      = 1'b0;
    in_burst       = 1'b0;
    out_burst      = 1'b0;
    out_stall      = 0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_if.valid    = 1'b0;
    in_if.mode     = MODE_LINE_IN;
    in_if.data_in  = 8'h00;
    in_if.tx_ready = 1'b0;
    out_if.ready   = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    load_config(pick_config(0));

    // Directed: overrun ordering, enables, master reset, spare modes
    send_item('{mode: MODE_RD_STAT, data_in: 8'h00, tx_ready: 1'b0});
    send_item('{mode: MODE_RD_STAT, data_in: 8'hFF, tx_ready: 1'b1});
    send_item('{mode: MODE_RD_DATA, data_in: 8'h00, tx_ready: 1'b0});
    send_item('{mode: MODE_LINE_IN, data_in: 8'h00, tx_ready: 1'b0});
    send_item('{mode: MODE_LINE_IN, data_in: 8'hFF, tx_ready: 1'b1});
    send_item('{mode: MODE_RD_STAT, data_in: 8'h00, tx_ready: 1'b1});
    send_item('{mode: MODE_RD_DATA, data_in: 8'h00, tx_ready: 1'b0});
    send_item('{mode: MODE_RD_STAT, data_in: 8'h00, tx_ready: 1'b0});
    send_item('{mode: MODE_LINE_IN, data_in: CH_LOWER_A, tx_ready: 1'b0});
    send_item('{mode: MODE_RD_DATA, data_in: 8'h00, tx_ready: 1'b0});
    send_item('{mode: MODE_WR_CTRL, data_in: CTRL_RX_IE | CTRL_TX_IE, tx_ready: 1'b0});
    send_item('{mode: MODE_RD_STAT, data_in: 8'h00, tx_ready: 1'b0});
    send_item('{mode: MODE_WR_DATA, data_in: CH_UNDERSCORE, tx_ready: 1'b0});
    send_item('{mode: MODE_RD_STAT, data_in: 8'h00, tx_ready: 1'b1});
    send_item('{mode: MODE_TX_TICK, data_in: 8'h00, tx_ready: 1'b0});
    send_item('{mode: MODE_LINE_IN, data_in: CH_BACKSPACE, tx_ready: 1'b0});
    send_item('{mode: MODE_WR_CTRL, data_in: CTRL_MRST_MASK, tx_ready: 1'b0});
    send_item('{mode: MODE_RD_STAT, data_in: 8'h00, tx_ready: 1'b0});
    send_item('{mode: MODE_WR_CTRL, data_in: 8'h40, tx_ready: 1'b0});
    send_item('{mode: MODE_WR_CTRL, data_in: CTRL_TX_MASK, tx_ready: 1'b0});
    send_item('{mode: MODE_WR_DATA, data_in: 8'hFF, tx_ready: 1'b1});
    send_item('{mode: MODE_SPARE_A, data_in: 8'hAA, tx_ready: 1'b1});
    send_item('{mode: MODE_SPARE_B, data_in: 8'h55, tx_ready: 1'b0});
    send_item('{mode: MODE_TX_TICK, data_in: 8'hFF, tx_ready: 1'b1});
    send_item('{mode: MODE_WR_DATA, data_in: 8'h00, tx_ready: 1'b0});

    for (int p = 0; p < PhaseCount; p++) begin
      if (p > 0) begin
        wait_drained(4);
        load_config(pick_config(p));
      end
      run_random(PhaseItems);
    end

    wait_drained(10);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
